@@ hw/rtl/scfp_pkg.sv @@
`default_nettype none

package scfp_pkg;

  // Payload store geometry.
  localparam int PAYLOAD_DEPTH = 32;
  localparam int ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

  // Field widths of one result beat.
  localparam int BYTE_W = 8;
  localparam int LEN_W = 7;
  localparam int IDX_W = 5;
  localparam int KIND_W = 2;
  localparam int TDATA_W = 40;

  // Result kinds carried in tuser.
  localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HDR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PAY = 2'd2;

  // Framing characters.
  localparam logic [BYTE_W-1:0] CH_LT = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_C = 8'h43;
  localparam logic [BYTE_W-1:0] CH_M = 8'h4D;
  localparam logic [BYTE_W-1:0] CH_D = 8'h44;
  localparam logic [BYTE_W-1:0] CH_GT = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_0 = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9 = 8'h39;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_frame;
    logic load_code;
    logic load_tens;
    logic load_units;
    logic store_byte;
    logic emit_echo;
    logic echo_last;
    logic emit_hdr;
    logic emit_pay;
  } scfp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_lt;
    logic is_c;
    logic is_m;
    logic is_d;
    logic is_gt;
    logic is_cr;
    logic is_digit;
    logic units_ok;
    logic rem_zero;
    logic len_zero;
    logic idx_last;
    logic out_free;
  } scfp_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/serial_command_frame_parser.sv @@
`default_nettype none
// A byte's echo beat is registered and appears in the cycle after the byte is accepted.
// Throughput: one byte per cycle while the output is drained; a completed frame then sends
// its header, then its payload bytes, each after a fetch state for the store's read port.
// No byte is accepted until the header, or for a frame with payload its last payload beat,
// has been loaded for output. Reset (rst, synchronous, active high) returns the parser to
// idle and empties the output; the payload store is not cleared.

module serial_command_frame_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  // Receive stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  // Result stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [7:0] echo_byte, [15:8] command_code, [22:16] frame_len,
  // [30:23] payload_byte, [35:31] payload_index, [39:36] zero
  output logic [39:0]      m_tdata,
  output logic [1:0]       m_tuser,   // [1:0] result_kind
  output logic             m_tlast    // last_result
);
  import scfp_pkg::*;

  // The controller owns the parser state and the output sequencing; the
  // datapath owns the frame registers, the payload store and the output
  // register, and classifies the incoming byte for the controller.
  scfp_cmd_t    cmd;
  scfp_status_t sts;

  scfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  scfp_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

`ifndef SYNTH
  // An echo that is not last means a frame just closed, so input must be held off.
  a_no_input_during_frame_out: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_ECHO && !m_tlast) |-> !s_tready)
    else $error("input accepted while a completed frame is pending");

  // A header beat is the last beat exactly when the frame has no payload.
  a_hdr_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_HDR) |-> (m_tlast == (m_tdata[22:16] == 7'd0)))
    else $error("header last flag disagrees with payload length");

  // Payload positions stay below the declared length.
  a_pay_index: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_PAY) |-> ({2'b00, m_tdata[35:31]} < m_tdata[22:16]))
    else $error("payload index beyond declared length");

  // The result kind never takes the unused code.
  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser == KIND_ECHO) || (m_tuser == KIND_HDR) || (m_tuser == KIND_PAY)))
    else $error("unused result kind");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/scfp_ctrl.sv @@
`default_nettype none

module scfp_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire scfp_pkg::scfp_status_t sts,
  output scfp_pkg::scfp_cmd_t        cmd
);
  import scfp_pkg::*;

  // Parser states.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LT = 4'd1;
  localparam logic [3:0] ST_C = 4'd2;
  localparam logic [3:0] ST_M = 4'd3;
  localparam logic [3:0] ST_D = 4'd4;
  localparam logic [3:0] ST_CODE = 4'd5;
  localparam logic [3:0] ST_TENS = 4'd6;
  localparam logic [3:0] ST_UNITS = 4'd7;
  localparam logic [3:0] ST_DATA = 4'd8;

  // Output phases.
  localparam logic [1:0] PH_RUN = 2'd0;
  localparam logic [1:0] PH_HDR = 2'd1;
  localparam logic [1:0] PH_FETCH = 2'd2;
  localparam logic [1:0] PH_SEND = 2'd3;

  logic [3:0] pstate;
  logic [3:0] pstate_next;
  logic [1:0] phase;
  logic [1:0] phase_next;
  logic       accept;
  logic       complete;

  assign s_tready = (phase == PH_RUN) && sts.out_free;
  assign accept = s_tvalid && s_tready;

  always_comb begin
    cmd = '0;
    pstate_next = pstate;
    phase_next = phase;
    complete = 1'b0;
    case (phase)
      PH_RUN: begin
        if (accept) begin
          cmd.emit_echo = 1'b1;
          pstate_next = ST_IDLE;
          case (pstate)
            ST_LT: if (sts.is_c) pstate_next = ST_C;
            ST_C: if (sts.is_m) pstate_next = ST_M;
            ST_M: if (sts.is_d) pstate_next = ST_D;
            ST_D: if (sts.is_gt) pstate_next = ST_CODE;
            ST_CODE: begin
              cmd.load_code = 1'b1;
              pstate_next = ST_TENS;
            end
            ST_TENS: begin
              if (sts.is_digit) begin
                cmd.load_tens = 1'b1;
                pstate_next = ST_UNITS;
              end
            end
            ST_UNITS: begin
              if (sts.is_digit && sts.units_ok) begin
                cmd.load_units = 1'b1;
                pstate_next = ST_DATA;
              end
            end
            ST_DATA: begin
              if (!sts.rem_zero) begin
                if (!sts.is_cr) begin
                  cmd.store_byte = 1'b1;
                  pstate_next = ST_DATA;
                end
              end else if (sts.is_cr) begin
                complete = 1'b1;
              end
            end
            default: begin
              // Idle, and any code without meaning, restarts frame tracking.
              cmd.clr_frame = 1'b1;
              if (sts.is_lt) pstate_next = ST_LT;
            end
          endcase
          cmd.echo_last = !complete;
          if (complete) phase_next = PH_HDR;
        end
      end
      PH_HDR: begin
        if (sts.out_free) begin
          cmd.emit_hdr = 1'b1;
          phase_next = sts.len_zero ? PH_RUN : PH_FETCH;
        end
      end
      PH_FETCH: begin
        phase_next = PH_SEND;
      end
      PH_SEND: begin
        if (sts.out_free) begin
          cmd.emit_pay = 1'b1;
          phase_next = sts.idx_last ? PH_RUN : PH_FETCH;
        end
      end
      default: begin
        phase_next = PH_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pstate <= ST_IDLE;
      phase <= PH_RUN;
    end else begin
      pstate <= pstate_next;
      phase <= phase_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/scfp_dp.sv @@
`default_nettype none

module scfp_dp (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [7:0]              s_tdata,
  input  wire scfp_pkg::scfp_cmd_t     cmd,
  output scfp_pkg::scfp_status_t       sts,
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  output logic [scfp_pkg::TDATA_W-1:0] m_tdata,
  output logic [scfp_pkg::KIND_W-1:0]  m_tuser,
  output logic                         m_tlast
);
  import scfp_pkg::*;

  logic [BYTE_W-1:0] frame_command;
  logic [LEN_W-1:0]  declared_length;
  logic [LEN_W-1:0]  bytes_remaining;
  logic [BYTE_W-1:0] mem [PAYLOAD_DEPTH];
  logic [ADDR_W-1:0] rd_idx;
  logic [BYTE_W-1:0] rd_data;

  logic [3:0]        digit;
  logic [LEN_W-1:0]  digit_ext;
  logic [LEN_W-1:0]  tens_value;
  logic [LEN_W-1:0]  units_sum;
  logic [LEN_W-1:0]  store_pos;

  // Output register fields.
  logic [BYTE_W-1:0] o_echo;
  logic [BYTE_W-1:0] o_code;
  logic [LEN_W-1:0]  o_len;
  logic [BYTE_W-1:0] o_pbyte;
  logic [IDX_W-1:0]  o_pidx;

  assign digit = 4'(s_tdata - CH_0);
  assign digit_ext = {3'b000, digit};
  assign tens_value = (digit_ext << 3) + (digit_ext << 1);
  assign units_sum = bytes_remaining + digit_ext;
  assign store_pos = declared_length - bytes_remaining;

  always_comb begin
    sts.is_lt = (s_tdata == CH_LT);
    sts.is_c = (s_tdata == CH_C);
    sts.is_m = (s_tdata == CH_M);
    sts.is_d = (s_tdata == CH_D);
    sts.is_gt = (s_tdata == CH_GT);
    sts.is_cr = (s_tdata == CH_CR);
    sts.is_digit = (s_tdata >= CH_0) && (s_tdata <= CH_9);
    sts.units_ok = (units_sum <= LEN_W'(PAYLOAD_DEPTH));
    sts.rem_zero = (bytes_remaining == '0);
    sts.len_zero = (declared_length == '0);
    sts.idx_last = ((LEN_W'(rd_idx) + LEN_W'(1)) == declared_length);
    sts.out_free = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_command <= '0;
      declared_length <= '0;
      bytes_remaining <= '0;
    end else begin
      if (cmd.clr_frame) begin
        frame_command <= '0;
        declared_length <= '0;
        bytes_remaining <= '0;
      end
      if (cmd.load_code) frame_command <= s_tdata;
      if (cmd.load_tens) bytes_remaining <= tens_value;
      if (cmd.load_units) begin
        bytes_remaining <= units_sum;
        declared_length <= units_sum;
      end
      if (cmd.store_byte) bytes_remaining <= bytes_remaining - LEN_W'(1);
    end
  end

  // Payload store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.store_byte) mem[store_pos[ADDR_W-1:0]] <= s_tdata;
    rd_data <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
    end else if (cmd.emit_hdr) begin
      rd_idx <= '0;
    end else if (cmd.emit_pay) begin
      rd_idx <= rd_idx + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_echo || cmd.emit_hdr || cmd.emit_pay) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_echo) begin
      m_tuser <= KIND_ECHO;
      m_tlast <= cmd.echo_last;
      o_echo <= s_tdata;
      o_code <= '0;
      o_len <= '0;
      o_pbyte <= '0;
      o_pidx <= '0;
    end else if (cmd.emit_hdr) begin
      m_tuser <= KIND_HDR;
      m_tlast <= (declared_length == '0);
      o_echo <= '0;
      o_code <= frame_command;
      o_len <= declared_length;
      o_pbyte <= '0;
      o_pidx <= '0;
    end else if (cmd.emit_pay) begin
      m_tuser <= KIND_PAY;
      m_tlast <= sts.idx_last;
      o_echo <= '0;
      o_code <= frame_command;
      o_len <= declared_length;
      o_pbyte <= rd_data;
      o_pidx <= IDX_W'(rd_idx);
    end
  end

  assign m_tdata = {4'b0000, o_pidx, o_pbyte, o_len, o_code, o_echo};

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`default_nettype none

module tb;
  import scfp_pkg::*;

  typedef enum logic [3:0] {
    P_IDLE, P_LT, P_C, P_M, P_D, P_CODE, P_TENS, P_UNITS, P_DATA
  } parse_t;

  typedef enum int {
    FR_GOOD, FR_EARLY_CR, FR_NO_CR, FR_BAD_DIGIT, FR_OVERSIZE, FR_BAD_MARK
  } frame_mode_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [7:0]        echo;
    logic [7:0]        code;
    logic [LEN_W-1:0]  len;
    logic [7:0]        pbyte;
    logic [IDX_W-1:0]  pidx;
    logic              last;
  } frame_beat_t;

  typedef struct {
    logic [7:0] b;
    logic       hold;
  } rx_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  serial_command_frame_parser u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Shadow of the parser state.
  parse_t           pstate = P_IDLE;
  logic [7:0]       frame_cmd = 8'h00;
  logic [LEN_W-1:0] decl_len = '0;
  logic [LEN_W-1:0] remain = '0;
  logic [7:0]       pay_mem [PAYLOAD_DEPTH];

  rx_item_t    rx_pending[$];
  frame_beat_t beats_owed[$];
  frame_beat_t want;
  int          bytes_sent = 0;
  int          beats_seen = 0;
  int          mismatches = 0;
  int          hold_at;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic push_beat(input logic [KIND_W-1:0] kind, input logic [7:0] echo,
                           input logic [7:0] pbyte, input int idx, input logic last);
    frame_beat_t fb;
    fb.kind  = kind;
    fb.echo  = echo;
    fb.code  = (kind == KIND_ECHO) ? 8'h00 : frame_cmd;
    fb.len   = (kind == KIND_ECHO) ? '0 : decl_len;
    fb.pbyte = pbyte;
    fb.pidx  = IDX_W'(idx);
    fb.last  = last;
    beats_owed.push_back(fb);
  endtask

  // Advances the shadow parser by one received byte and queues the beats it causes.
  task automatic parse_rx_byte(input logic [7:0] b);
    parse_t nxt;
    logic   done;
    logic   digit;
    int     n;
    nxt = P_IDLE;
    done = 1'b0;
    digit = (b >= CH_0) && (b <= CH_9);
    case (pstate)
      P_LT: if (b == CH_C) nxt = P_C;
      P_C: if (b == CH_M) nxt = P_M;
      P_M: if (b == CH_D) nxt = P_D;
      P_D: if (b == CH_GT) nxt = P_CODE;
      P_CODE: begin
        frame_cmd = b;
        nxt = P_TENS;
      end
      P_TENS: if (digit) begin
        remain = LEN_W'((int'(b) - int'(CH_0)) * 10);
        nxt = P_UNITS;
      end
      P_UNITS: if (digit) begin
        n = int'(remain) + int'(b) - int'(CH_0);
        if (n <= PAYLOAD_DEPTH) begin
          remain = LEN_W'(n);
          decl_len = LEN_W'(n);
          nxt = P_DATA;
        end
      end
      P_DATA: begin
        if (remain != 0) begin
          // A carriage return while payload is still owed drops the frame.
          if (b != CH_CR) begin
            pay_mem[int'(decl_len) - int'(remain)] = b;
            remain = remain - 1'b1;
            nxt = P_DATA;
          end
        end else if (b == CH_CR) begin
          done = 1'b1;
        end
      end
      default: begin
        frame_cmd = 8'h00;
        decl_len = '0;
        remain = '0;
        if (b == CH_LT) nxt = P_LT;
      end
    endcase
    pstate = nxt;
    push_beat(KIND_ECHO, b, 8'h00, 0, !done);
    if (done) begin
      push_beat(KIND_HDR, 8'h00, 8'h00, 0, decl_len == 0);
      for (n = 0; n < int'(decl_len); n++)
        push_beat(KIND_PAY, 8'h00, pay_mem[n], n, n + 1 == int'(decl_len));
    end
  endtask

  task automatic add_byte(input logic [7:0] b);
    rx_item_t it;
    it.b = b;
    it.hold = 1'b0;
    rx_pending.push_back(it);
  endtask

  function automatic logic [7:0] non_digit();
    logic [7:0] b;
    b = 8'($urandom_range(0, 245));
    if (b >= CH_0) b = b + 8'd10;
    return b;
  endfunction

  // Queues one frame; the mode decides where, if anywhere, it goes wrong.
  task automatic add_frame(input logic [7:0] code, input int len, input frame_mode_t mode);
    logic [7:0] mark [5];
    logic [7:0] pb;
    int         bad_at;
    int         cnt;
    int         i;
    mark = '{CH_LT, CH_C, CH_M, CH_D, CH_GT};
    bad_at = (mode == FR_BAD_MARK) ? $urandom_range(1, 4) : 5;
    for (i = 0; i < 5; i++) begin
      if (i == bad_at) begin
        add_byte(8'($urandom_range(0, 255)));
        return;
      end
      add_byte(mark[i]);
    end
    add_byte(code);
    if (mode == FR_BAD_DIGIT && $urandom_range(0, 1) == 1) begin
      add_byte(non_digit());
      return;
    end
    add_byte(8'(int'(CH_0) + len / 10));
    if (mode == FR_BAD_DIGIT) begin
      add_byte(non_digit());
      return;
    end
    add_byte(8'(int'(CH_0) + len % 10));
    if (mode == FR_OVERSIZE) return;
    cnt = (mode == FR_EARLY_CR) ? len - 1 : len;
    for (i = 0; i < cnt; i++) begin
      pb = 8'($urandom_range(0, 255));
      if (pb == CH_CR) pb = 8'h0E;
      add_byte(pb);
    end
    if (mode == FR_NO_CR) begin
      pb = 8'($urandom_range(0, 254));
      if (pb >= CH_CR) pb = pb + 8'd1;
      add_byte(pb);
    end else begin
      add_byte(CH_CR);
    end
  endtask

  task automatic check_field(input string name, input logic [39:0] exp_v,
                             input logic [39:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, got_v);
      mismatches++;
    end
  endtask

  // Sender: beats are taken from the pending queue; predictions are made on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= 8'h00;
    end else begin
      if (s_tvalid && s_tready) begin
        parse_rx_byte(s_tdata);
        bytes_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (rx_pending.size() != 0 && !(rx_pending[0].hold && beats_owed.size() != 0) &&
            !((bytes_sent < 60 || bytes_sent >= 110) && $urandom_range(0, 99) < 23)) begin
          s_tvalid <= 1'b1;
          s_tdata <= rx_pending[0].b;
          rx_pending.delete(0);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result beat against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        beats_seen++;
        if (beats_owed.size() == 0) begin
          $display("%0t: no beat expected, actual kind %0h data %0h last %0b",
                   $time, m_tuser, m_tdata, m_tlast);
          mismatches++;
        end else begin
          want = beats_owed.pop_front();
          check_field("result_kind", 40'(want.kind), 40'(m_tuser));
          check_field("echo_byte", 40'(want.echo), 40'(m_tdata[7:0]));
          check_field("command_code", 40'(want.code), 40'(m_tdata[15:8]));
          check_field("frame_len", 40'(want.len), 40'(m_tdata[22:16]));
          check_field("payload_byte", 40'(want.pbyte), 40'(m_tdata[30:23]));
          check_field("payload_index", 40'(want.pidx), 40'(m_tdata[35:31]));
          check_field("tdata padding", 40'(0), 40'(m_tdata[39:36]));
          check_field("last_result", 40'(want.last), 40'(m_tlast));
        end
      end
      m_tready <= (beats_seen >= 100 && beats_seen < 200) || $urandom_range(0, 99) >= 23;
    end
  end

  initial begin
    int          r;
    int          len;
    frame_mode_t mode;

    // Directed: byte extremes, an empty frame, an oversized length and a repeated
    // start marker whose second copy must not restart the frame.
    add_byte(8'h00);
    add_byte(8'hFF);
    add_frame(8'hFF, 0, FR_GOOD);
    add_frame(8'h00, PAYLOAD_DEPTH + 1, FR_OVERSIZE);
    add_byte(CH_LT);
    add_byte(CH_LT);
    add_byte(CH_C);

    // The first random frame waits until the directed part has fully drained.
    hold_at = rx_pending.size();
    add_frame(8'($urandom_range(0, 255)), PAYLOAD_DEPTH, FR_GOOD);
    rx_pending[hold_at].hold = 1'b1;
    add_frame(8'($urandom_range(0, 255)), $urandom_range(1, 8), FR_EARLY_CR);
    add_frame(8'($urandom_range(0, 255)), $urandom_range(0, 8), FR_NO_CR);
    add_frame(8'($urandom_range(0, 255)), 99, FR_OVERSIZE);

    while (rx_pending.size() < 150) begin
      r = $urandom_range(0, 99);
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, PAYLOAD_DEPTH)
                                         : $urandom_range(0, 6);
      if (r < 60) mode = FR_GOOD;
      else if (r < 66) mode = FR_EARLY_CR;
      else if (r < 72) mode = FR_NO_CR;
      else if (r < 78) mode = FR_BAD_DIGIT;
      else if (r < 84) mode = FR_OVERSIZE;
      else if (r < 90) mode = FR_BAD_MARK;
      else mode = FR_GOOD;
      if (mode == FR_EARLY_CR && len == 0) len = 1;
      if (mode == FR_OVERSIZE) len = $urandom_range(PAYLOAD_DEPTH + 1, 99);
      if (r >= 90) begin
        repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
      end else begin
        add_frame(8'($urandom_range(0, 255)), len, mode);
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (rx_pending.size() != 0 || s_tvalid || beats_owed.size() != 0)
      @(negedge clk);
    repeat (20) @(negedge clk);

    if (mismatches == 0 && beats_owed.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
